/* rtl/ascii_hex_reply_frame_parser_core_macros.svh */
// Assertion helpers shared by the parser RTL.
`ifndef ASCII_HEX_REPLY_FRAME_PARSER_CORE_MACROS_SVH
`define ASCII_HEX_REPLY_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AHRFP_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AHRFP_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error(msg);

`endif

/* rtl/ahrfp_pkg.sv */
`timescale 1ns / 1ps
package ahrfp_pkg;

    localparam int MAX_ANALOG_SLOTS = 8;
    localparam int SLOT_IDX_W       = $clog2(MAX_ANALOG_SLOTS);
    localparam int ANALOG_W         = 8 * MAX_ANALOG_SLOTS;
    localparam int DIGITAL_W        = 16;
    localparam int MODE_W           = 4;
    localparam int CNT_W            = 5;
    localparam int KIND_W           = 3;
    localparam int M_TDATA_W        = 88;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_LO_H  = 8'h68;
    localparam logic [7:0] CHAR_LO_L  = 8'h6C;
    localparam logic [7:0] CHAR_UP_N  = 8'h4E;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_UP_I  = 8'h49;
    localparam logic [7:0] CHAR_LO_I  = 8'h69;
    localparam logic [7:0] CHAR_UP_R  = 8'h52;
    localparam logic [7:0] CHAR_LO_R  = 8'h72;

    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LED_ON  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LED_OFF = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ANALOG  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DIGITAL = 3'd6;
    localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]    frame_kind;
        logic                 to_reply_queue;
        logic                 led_on;
        logic [ANALOG_W-1:0]  analog_values;
        logic [DIGITAL_W-1:0] digital_value;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [KIND_W-1:0] kind_decode(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CHAR_BANG:            k = KIND_ERROR;
            CHAR_LO_H:            k = KIND_LED_ON;
            CHAR_LO_L:            k = KIND_LED_OFF;
            CHAR_UP_N:            k = KIND_PRESS;
            CHAR_UP_F:            k = KIND_RELEASE;
            CHAR_UP_I, CHAR_LO_I: k = KIND_ANALOG;
            CHAR_UP_R, CHAR_LO_R: k = KIND_DIGITAL;
            default:              k = KIND_OTHER;
        endcase
        return k;
    endfunction

    // analog slot count per board mode
    function automatic logic [3:0] slots_for_mode(input logic [MODE_W-1:0] m);
        logic [3:0] n;
        case (m)
            4'd1, 4'd3, 4'd8: n = 4'd4;
            4'd2, 4'd4:       n = 4'd8;
            default:          n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/ahrfp_in_reg.sv */
`timescale 1ns / 1ps
module ahrfp_in_reg
    import ahrfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       out_free,
    output logic [7:0] byte_q,
    output logic       fire
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // a '*' word needs room in the result register; other words always move on
    assign fire     = valid_reg && ((byte_reg != CHAR_STAR) || out_free);
    assign s_tready = !valid_reg || fire;
    assign byte_q   = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

/* rtl/ahrfp_parse.sv */
`timescale 1ns / 1ps
module ahrfp_parse
    import ahrfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        byte_q,
    input  logic [MODE_W-1:0] mode,
    output logic              res_load,
    output res_t              res
);

    logic                 at_start_reg, at_start_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 queued_reg, queued_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 stopped_reg, stopped_next;
    logic [3:0]           hn_reg, hn_next;
    logic [DIGITAL_W-1:0] acc_reg, acc_next;
    logic [7:0]           slots_reg [MAX_ANALOG_SLOTS];
    logic [7:0]           slots_next [MAX_ANALOG_SLOTS];
    logic [DIGITAL_W-1:0] word_reg, word_next;
    logic                 led_reg, led_next;

    logic                 is_star;
    hex_t                 hx;
    logic [3:0]           n_slots;
    logic [ANALOG_W-1:0]  packed_slots;

    assign is_star  = (byte_q == CHAR_STAR);
    assign hx       = hex_decode(byte_q);
    assign n_slots  = slots_for_mode(mode);
    assign res_load = fire && is_star;

    always_comb begin
        for (int k = 0; k < MAX_ANALOG_SLOTS; k++) begin
            packed_slots[8*k +: 8] = slots_reg[k];
        end
    end

    // result reflects the frame applied at '*'
    always_comb begin
        res.analog_values = packed_slots;
        if (at_start_reg) begin
            res.frame_kind     = KIND_OTHER;
            res.to_reply_queue = 1'b1;
        end else begin
            res.frame_kind     = kind_reg;
            res.to_reply_queue = queued_reg;
        end
        res.led_on = led_reg;
        if (!at_start_reg && kind_reg == KIND_LED_ON) begin
            res.led_on = 1'b1;
        end else if (!at_start_reg && kind_reg == KIND_LED_OFF) begin
            res.led_on = 1'b0;
        end
        res.digital_value = word_reg;
        if (!at_start_reg && kind_reg == KIND_DIGITAL && cnt_reg != '0) begin
            res.digital_value = acc_reg;
        end
    end

    always_comb begin
        at_start_next = at_start_reg;
        kind_next     = kind_reg;
        queued_next   = queued_reg;
        cnt_next      = cnt_reg;
        stopped_next  = stopped_reg;
        hn_next       = hn_reg;
        acc_next      = acc_reg;
        word_next     = word_reg;
        led_next      = led_reg;
        for (int k = 0; k < MAX_ANALOG_SLOTS; k++) begin
            slots_next[k] = slots_reg[k];
        end
        if (fire) begin
            if (is_star) begin
                kind_next     = res.frame_kind;
                queued_next   = res.to_reply_queue;
                led_next      = res.led_on;
                word_next     = res.digital_value;
                at_start_next = 1'b1;
                cnt_next      = '0;
                stopped_next  = 1'b0;
                hn_next       = 4'd0;
                acc_next      = '0;
            end else if (at_start_reg) begin
                kind_next     = kind_decode(byte_q);
                queued_next   = !(byte_q == CHAR_LO_R || byte_q == CHAR_LO_I
                                  || byte_q == CHAR_UP_N || byte_q == CHAR_UP_F);
                at_start_next = 1'b0;
            end else if ((kind_reg == KIND_ANALOG || kind_reg == KIND_DIGITAL)
                         && !stopped_reg) begin
                if (!hx.ok) begin
                    stopped_next = 1'b1;
                end else if (kind_reg == KIND_DIGITAL) begin
                    if (cnt_reg < CNT_W'(4)) begin
                        acc_next = {acc_reg[DIGITAL_W-5:0], hx.val};
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else if (cnt_reg < {n_slots, 1'b0}) begin
                    if (!cnt_reg[0]) begin
                        hn_next = hx.val;
                    end else begin
                        slots_next[cnt_reg[SLOT_IDX_W:1]] = {hn_reg, hx.val};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            kind_reg     <= KIND_ERROR;
            queued_reg   <= 1'b0;
            cnt_reg      <= '0;
            stopped_reg  <= 1'b0;
            hn_reg       <= 4'd0;
            acc_reg      <= '0;
            word_reg     <= '0;
            led_reg      <= 1'b0;
            for (int k = 0; k < MAX_ANALOG_SLOTS; k++) begin
                slots_reg[k] <= 8'd0;
            end
        end else begin
            at_start_reg <= at_start_next;
            kind_reg     <= kind_next;
            queued_reg   <= queued_next;
            cnt_reg      <= cnt_next;
            stopped_reg  <= stopped_next;
            hn_reg       <= hn_next;
            acc_reg      <= acc_next;
            word_reg     <= word_next;
            led_reg      <= led_next;
            for (int k = 0; k < MAX_ANALOG_SLOTS; k++) begin
                slots_reg[k] <= slots_next[k];
            end
        end
    end

endmodule

/* rtl/ahrfp_out_reg.sv */
`timescale 1ns / 1ps
module ahrfp_out_reg
    import ahrfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_load,
    input  res_t                 res,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser
);

    localparam int PAY_W = 2 + ANALOG_W + DIGITAL_W;

    logic       valid_reg, valid_next;
    res_t       res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.frame_kind;
    assign m_tdata  = {{(M_TDATA_W - PAY_W){1'b0}}, res_reg.digital_value,
                       res_reg.analog_values, res_reg.led_on, res_reg.to_reply_queue};

    always_comb begin
        valid_next = valid_reg;
        if (res_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/ascii_hex_reply_frame_parser_core.sv */
// Reply frame parser for an ASCII hex serial I/O board.
// s_ channel: one received byte per word (s_tdata[7:0]). m_ channel: one word
// per '*' frame terminator, carrying the frame kind in m_tuser and the tracked
// LED, analog slot and digital values after that frame in m_tdata.
// cfg_ channel: writes the 4-bit board mode, which sets the analog slot count;
// write it only while the parser is idle. cfg_ready is always high.
// Bytes pass the input register, the single decode stage and, for a '*', the
// result register, which drives m_tvalid; a non-'*' byte is decoded in the
// next cycle. Throughput is one byte per cycle unless a '*' must wait in the
// input register for the result register. When m_tready is low and a result
// waits, non-'*' bytes keep flowing; a second '*' is held in the input register,
// and s_tready drops once that register is full and blocked.
// Reset (aresetn low, synchronous) clears the mode, the LED flag, all analog
// slots and the digital word, and starts a new frame.
`timescale 1ns / 1ps
`include "ascii_hex_reply_frame_parser_core_macros.svh"
module ascii_hex_reply_frame_parser_core
    import ahrfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] to_reply_queue, [1] led_on, [65:2] analog_values,
    // [81:66] digital_value, [87:82] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,    // [2:0] frame_kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MODE_W-1:0]    cfg_data    // [3:0] config_mode
);

    logic [MODE_W-1:0] mode_reg;
    logic              out_free;
    logic              fire;
    logic [7:0]        byte_q;
    logic              res_load;
    res_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    ahrfp_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .byte_q   (byte_q),
        .fire     (fire)
    );

    ahrfp_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .byte_q   (byte_q),
        .mode     (mode_reg),
        .res_load (res_load),
        .res      (res)
    );

    ahrfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `AHRFP_ASSERT_NXT(a_star_gives_result, aclk, aresetn, res_load, m_tvalid, "star lost")
    `AHRFP_ASSERT_IMP(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready, !res_load, "result overwritten")
    `AHRFP_ASSERT_IMP(a_load_only_on_star, aclk, aresetn, res_load, byte_q == CHAR_STAR, "result without star")
    `AHRFP_ASSERT_IMP(a_stall_only_blocked, aclk, aresetn, !s_tready, !out_free && byte_q == CHAR_STAR, "bad input stall")

endmodule
